[rtl/core/sfkh_pkg.sv]
// Package for the symmetric flow key hash block.
// Holds the hash constants, key layout sizes and shared types; no dependencies.
`timescale 1ns / 1ps
package sfkh_pkg;

   localparam int unsigned KEY_BYTES  = 37;
   localparam int unsigned KEY_BITS   = KEY_BYTES * 8;
   localparam int unsigned WORD_BITS  = 32;
   localparam int unsigned HASH_SHIFT = 16;
   localparam logic [31:0] HASH_MULT  = 32'hc6a4a793;

   localparam logic [7:0] KEY4_LEN = 8'd13;
   localparam logic [7:0] KEY6_LEN = 8'd37;

   localparam int unsigned ROUND_BITS = 4;
   localparam logic [ROUND_BITS-1:0] ROUNDS4 = 4'd3;
   localparam logic [ROUND_BITS-1:0] ROUNDS6 = 4'd9;

   typedef logic [KEY_BITS-1:0] key_type;

   typedef struct packed {
      logic [63:0] addr_hi;
      logic [63:0] addr_lo;
      logic [15:0] port;
   } endpoint_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic mix;
   } round_ctrl_type;

endpackage

[rtl/core/sfkh_order.sv]
// Endpoint ordering and session key assembly for the flow key hash.
// Uses sfkh_pkg for the key layout and endpoint type.
`timescale 1ns / 1ps
module sfkh_order (
   input  logic                  mode,
   input  sfkh_pkg::endpoint_type ep_a,
   input  sfkh_pkg::endpoint_type ep_b,
   output sfkh_pkg::endpoint_type first,
   output sfkh_pkg::endpoint_type second,
   output sfkh_pkg::key_type      key,
   output logic [31:0]            seed,
   output logic [sfkh_pkg::ROUND_BITS-1:0] rounds
);

   sfkh_pkg::endpoint_type a_m;
   sfkh_pkg::endpoint_type b_m;
   logic                   a_first;

   always_comb begin
      a_m = ep_a;
      b_m = ep_b;
      // IPv4: drop the unused address bits
      if (!mode) begin
         a_m.addr_hi = 64'd0;
         b_m.addr_hi = 64'd0;
         a_m.addr_lo = {32'd0, ep_a.addr_lo[31:0]};
         b_m.addr_lo = {32'd0, ep_b.addr_lo[31:0]};
      end
   end

   assign a_first = a_m < b_m;
   assign first   = a_first ? a_m : b_m;
   assign second  = a_first ? b_m : a_m;

   always_comb begin
      key = '0;
      if (mode) begin
         key[7:0] = sfkh_pkg::KEY6_LEN;
         for (int i = 0; i < 8; i++) begin
            key[8*(1+i)  +: 8] = first.addr_hi[8*(7-i) +: 8];
            key[8*(9+i)  +: 8] = first.addr_lo[8*(7-i) +: 8];
            key[8*(19+i) +: 8] = second.addr_hi[8*(7-i) +: 8];
            key[8*(27+i) +: 8] = second.addr_lo[8*(7-i) +: 8];
         end
         key[8*17 +: 8] = first.port[15:8];
         key[8*18 +: 8] = first.port[7:0];
         key[8*35 +: 8] = second.port[15:8];
         key[8*36 +: 8] = second.port[7:0];
         seed   = {24'd0, key[8*36 +: 8]};
         rounds = sfkh_pkg::ROUNDS6;
      end else begin
         key[7:0]       = sfkh_pkg::KEY4_LEN;
         key[39:8]      = first.addr_lo[31:0];
         key[8*5 +: 8]  = first.port[15:8];
         key[8*6 +: 8]  = first.port[7:0];
         key[87:56]     = second.addr_lo[31:0];
         key[8*11 +: 8] = second.port[15:8];
         key[8*12 +: 8] = second.port[7:0];
         seed   = {24'd0, key[8*12 +: 8]};
         rounds = sfkh_pkg::ROUNDS4;
      end
   end

endmodule

[rtl/core/sfkh_round.sv]
// Shared hash round unit: add word, multiply by constant, xor-shift.
// Uses sfkh_pkg for the multiplier constant and control struct.
`timescale 1ns / 1ps
module sfkh_round (
   input  logic                    clock,
   input  sfkh_pkg::round_ctrl_type ctrl,
   input  logic [31:0]             seed,
   input  logic [31:0]             word,
   output logic [31:0]             hash
);

   logic [31:0] h_ff, h_in;
   logic [31:0] prod_ff, prod_in;
   logic [31:0] sum;

   assign sum     = h_ff + word;
   assign prod_in = 32'(sum * sfkh_pkg::HASH_MULT);

   always_comb begin
      h_in = h_ff;
      if (ctrl.load) begin
         h_in = seed;
      end else if (ctrl.mix) begin
         h_in = prod_ff ^ (prod_ff >> sfkh_pkg::HASH_SHIFT);
      end
   end

   always_ff @(posedge clock) begin
      h_ff <= h_in;
      if (ctrl.mul) begin
         prod_ff <= prod_in;
      end
   end

   assign hash = h_ff;

endmodule

[rtl/core/symmetric_flow_key_hash.sv]
// Top level of the symmetric flow key hash: sequencer, key register, output slot.
// Uses sfkh_pkg, sfkh_order and sfkh_round.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_tvalid/tready    | req_tdata, 296 bits
//   rsp     | out       | rsp_tvalid/tready    | rsp_tdata, 320 bits
//   csr     | in        | csr_valid/csr_ready  | csr_data, hash_salt
//
// Each key word takes a multiply step and then an xor-shift step on the shared
// multiply unit: 3 words for IPv4, 9 for IPv6. A new item is taken only once the
// previous one has left the sequencer for the output register.
// reset is synchronous and clears the sequencer, the output valid and the salt.
// A stalled result sits in the output register while the next item runs.
`timescale 1ns / 1ps
module symmetric_flow_key_hash (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // mode[0], addr_a_hi[64:1], addr_a_lo[128:65], port_a[144:129],
   // addr_b_hi[208:145], addr_b_lo[272:209], port_b[288:273], zero[295:289]
   input  logic [295:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // flow_hash[31:0], first_addr_hi[95:32], first_addr_lo[159:96],
   // first_port[175:160], second_addr_hi[239:176], second_addr_lo[303:240],
   // second_port[319:304]
   output logic [319:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [31:0]  csr_data
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MUL  = 2'd1;
   localparam logic [1:0] S_MIX  = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [sfkh_pkg::ROUND_BITS-1:0] left_ff, left_in;
   sfkh_pkg::key_type key_ff, key_in;
   sfkh_pkg::endpoint_type first_ff, first_in, second_ff, second_in;
   logic [31:0] salt_ff, salt_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [319:0] rsp_data_ff, rsp_data_in;

   sfkh_pkg::endpoint_type ep_a, ep_b, ord_first, ord_second;
   sfkh_pkg::key_type      ord_key;
   logic [31:0]            ord_seed;
   logic [sfkh_pkg::ROUND_BITS-1:0] ord_rounds;
   sfkh_pkg::round_ctrl_type ctrl;
   logic [31:0] hash;
   logic        req_take, out_load;

   assign ep_a = '{addr_hi: req_tdata[64:1], addr_lo: req_tdata[128:65],
                   port: req_tdata[144:129]};
   assign ep_b = '{addr_hi: req_tdata[208:145], addr_lo: req_tdata[272:209],
                   port: req_tdata[288:273]};

   sfkh_order u_order (
      .mode   (req_tdata[0]),
      .ep_a   (ep_a),
      .ep_b   (ep_b),
      .first  (ord_first),
      .second (ord_second),
      .key    (ord_key),
      .seed   (ord_seed),
      .rounds (ord_rounds)
   );

   sfkh_round u_round (
      .clock (clock),
      .ctrl  (ctrl),
      .seed  (ord_seed),
      .word  (key_ff[sfkh_pkg::WORD_BITS-1:0]),
      .hash  (hash)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign out_load   = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);
   assign csr_ready  = 1'b1;

   always_comb begin
      state_in  = state_ff;
      left_in   = left_ff;
      key_in    = key_ff;
      first_in  = first_ff;
      second_in = second_ff;
      ctrl      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               ctrl.load = 1'b1;
               key_in    = ord_key;
               first_in  = ord_first;
               second_in = ord_second;
               left_in   = ord_rounds;
               state_in  = S_MUL;
            end
         end
         S_MUL: begin
            ctrl.mul = 1'b1;
            state_in = S_MIX;
         end
         S_MIX: begin
            ctrl.mix = 1'b1;
            // advance to the next little-endian word
            key_in   = key_ff >> sfkh_pkg::WORD_BITS;
            left_in  = left_ff - 1'b1;
            state_in = (left_ff == 1) ? S_DONE : S_MUL;
         end
         S_DONE: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result fields from the lowest bit up: hash, then hi, lo, port of each endpoint
   assign rsp_data_in  = {second_ff.port, second_ff.addr_lo, second_ff.addr_hi,
                          first_ff.port, first_ff.addr_lo, first_ff.addr_hi,
                          hash ^ salt_ff};
   assign rsp_valid_in = (rsp_valid_ff && !rsp_tready) || out_load;
   assign salt_in      = (csr_valid && csr_ready) ? csr_data : salt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         salt_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
         salt_ff      <= salt_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      first_ff  <= first_in;
      second_ff <= second_in;
      if (out_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[test/tb.sv]
// Self-checking bench for symmetric_flow_key_hash: directed table, then random flows.
// Predicts canonical endpoint order and salted key hash; needs sfkh_pkg and the block.
`timescale 1ns / 1ps
module tb;

   typedef enum logic {
      MODE_V4 = 1'b0,
      MODE_V6 = 1'b1
   } ip_mode_t;

   typedef enum int {
      ORDER_CALC,
      ORDER_A,
      ORDER_B
   } order_pick_t;

   // lowest bit first: mode, addr_a_hi, addr_a_lo, port_a, addr_b_hi, addr_b_lo, port_b, pad
   typedef struct packed {
      logic [6:0]  pad;
      logic [15:0] port_b;
      logic [63:0] addr_b_lo;
      logic [63:0] addr_b_hi;
      logic [15:0] port_a;
      logic [63:0] addr_a_lo;
      logic [63:0] addr_a_hi;
      ip_mode_t    mode;
   } flow_item_t;

   // lowest bit first: flow_hash, first hi/lo/port, second hi/lo/port
   typedef struct packed {
      logic [15:0] second_port;
      logic [63:0] second_addr_lo;
      logic [63:0] second_addr_hi;
      logic [15:0] first_port;
      logic [63:0] first_addr_lo;
      logic [63:0] first_addr_hi;
      logic [31:0] flow_hash;
   } flow_result_t;

   typedef struct {
      flow_item_t  item;
      order_pick_t pick;
   } plan_row_t;

   localparam logic [31:0] MIX_MULT   = 32'hc6a4a793;
   localparam int          MIX_SHIFT  = 16;
   localparam int          KEY4_BYTES = 13;
   localparam int          KEY6_BYTES = 37;
   localparam logic [63:0] ONES64     = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam int          HOLD_CYCLES = 300;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [295:0]  req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [319:0]  rsp_tdata;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   logic [31:0]   csr_data = '0;

   flow_result_t  expected_flows[$];
   logic [31:0]   salt_shadow = '0;
   int            mismatches = 0;
   int            tx_idle_pct = 0;
   int            rx_idle_pct = 0;
   int            hold_requests = 0;
   int            holds_served = 0;
   int            hold_left = 0;
   flow_result_t  got_flow;
   flow_result_t  want_flow;

   symmetric_flow_key_hash dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("[symmetric_flow_key_hash] ERROR");
      $finish;
   end

   // IPv4 keeps only the low 32 address bits
   function automatic sfkh_pkg::endpoint_type endpoint_of(input ip_mode_t mode,
         input logic [63:0] hi, input logic [63:0] lo, input logic [15:0] port);
      sfkh_pkg::endpoint_type e;
      e.addr_hi = (mode == MODE_V6) ? hi : 64'd0;
      e.addr_lo = (mode == MODE_V6) ? lo : {32'd0, lo[31:0]};
      e.port    = port;
      return e;
   endfunction

   function automatic flow_result_t hashed_flow(input ip_mode_t mode,
         input sfkh_pkg::endpoint_type first, input sfkh_pkg::endpoint_type second,
         input logic [31:0] salt);
      logic [7:0]   key [KEY6_BYTES];
      int           len;
      logic [31:0]  h;
      flow_result_t r;
      for (int i = 0; i < KEY6_BYTES; i++) key[i] = 8'd0;
      if (mode == MODE_V6) begin
         len    = KEY6_BYTES;
         key[0] = 8'(KEY6_BYTES);
         for (int i = 0; i < 8; i++) begin
            key[1 + i]  = first.addr_hi[63 - 8*i -: 8];
            key[9 + i]  = first.addr_lo[63 - 8*i -: 8];
            key[19 + i] = second.addr_hi[63 - 8*i -: 8];
            key[27 + i] = second.addr_lo[63 - 8*i -: 8];
         end
         key[17] = first.port[15:8];
         key[18] = first.port[7:0];
         key[35] = second.port[15:8];
         key[36] = second.port[7:0];
      end else begin
         len    = KEY4_BYTES;
         key[0] = 8'(KEY4_BYTES);
         // IPv4 addresses go in least significant byte first
         for (int i = 0; i < 4; i++) begin
            key[1 + i] = first.addr_lo[8*i +: 8];
            key[7 + i] = second.addr_lo[8*i +: 8];
         end
         key[5]  = first.port[15:8];
         key[6]  = first.port[7:0];
         key[11] = second.port[15:8];
         key[12] = second.port[7:0];
      end
      // seed from the last byte, which no word covers
      h = {24'd0, key[len - 1]};
      for (int pos = 0; pos + 4 < len; pos += 4) begin
         h = (h + {key[pos + 3], key[pos + 2], key[pos + 1], key[pos]}) * MIX_MULT;
         h = h ^ (h >> MIX_SHIFT);
      end
      r.flow_hash      = h ^ salt;
      r.first_addr_hi  = first.addr_hi;
      r.first_addr_lo  = first.addr_lo;
      r.first_port     = first.port;
      r.second_addr_hi = second.addr_hi;
      r.second_addr_lo = second.addr_lo;
      r.second_port    = second.port;
      return r;
   endfunction

   function automatic flow_result_t predict_flow(input flow_item_t f, input logic [31:0] salt);
      sfkh_pkg::endpoint_type ea;
      sfkh_pkg::endpoint_type eb;
      ea = endpoint_of(f.mode, f.addr_a_hi, f.addr_a_lo, f.port_a);
      eb = endpoint_of(f.mode, f.addr_b_hi, f.addr_b_lo, f.port_b);
      // packed compare is hi, then lo, then port; ties put b first
      if (ea < eb) return hashed_flow(f.mode, ea, eb, salt);
      return hashed_flow(f.mode, eb, ea, salt);
   endfunction

   function automatic plan_row_t plan_row(input ip_mode_t mode,
         input logic [63:0] ahi, input logic [63:0] alo, input logic [15:0] ap,
         input logic [63:0] bhi, input logic [63:0] blo, input logic [15:0] bp,
         input order_pick_t pick);
      plan_row_t r;
      r.item           = '0;
      r.item.mode      = mode;
      r.item.addr_a_hi = ahi;
      r.item.addr_a_lo = alo;
      r.item.port_a    = ap;
      r.item.addr_b_hi = bhi;
      r.item.addr_b_lo = blo;
      r.item.port_b    = bp;
      r.pick           = pick;
      return r;
   endfunction

   task automatic note_mismatch(input string what, input logic [63:0] got,
         input logic [63:0] want);
      $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
      mismatches++;
   endtask

   task automatic send_flow(input flow_item_t f, input flow_result_t want);
      int gap;
      req_tdata  <= f;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      expected_flows.push_back(want);
      gap = 0;
      while ($urandom_range(99) < tx_idle_pct) gap++;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_salt(input logic [31:0] value);
      req_tvalid <= 1'b0;
      while (expected_flows.size() != 0) @(posedge clock);
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid   <= 1'b0;
      salt_shadow = value;
   endtask

   // result side: random back-pressure plus a long hold on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_flow = rsp_tdata;
         if (expected_flows.size() == 0) begin
            note_mismatch("result with no item pending", {32'd0, got_flow.flow_hash}, 64'd0);
         end else begin
            want_flow = expected_flows.pop_front();
            if (got_flow.flow_hash != want_flow.flow_hash)
               note_mismatch("flow_hash", {32'd0, got_flow.flow_hash},
                             {32'd0, want_flow.flow_hash});
            if (got_flow.first_addr_hi != want_flow.first_addr_hi)
               note_mismatch("first_addr_hi", got_flow.first_addr_hi, want_flow.first_addr_hi);
            if (got_flow.first_addr_lo != want_flow.first_addr_lo)
               note_mismatch("first_addr_lo", got_flow.first_addr_lo, want_flow.first_addr_lo);
            if (got_flow.first_port != want_flow.first_port)
               note_mismatch("first_port", {48'd0, got_flow.first_port},
                             {48'd0, want_flow.first_port});
            if (got_flow.second_addr_hi != want_flow.second_addr_hi)
               note_mismatch("second_addr_hi", got_flow.second_addr_hi,
                             want_flow.second_addr_hi);
            if (got_flow.second_addr_lo != want_flow.second_addr_lo)
               note_mismatch("second_addr_lo", got_flow.second_addr_lo,
                             want_flow.second_addr_lo);
            if (got_flow.second_port != want_flow.second_port)
               note_mismatch("second_port", {48'd0, got_flow.second_port},
                             {48'd0, want_flow.second_port});
         end
      end
   end

   initial begin : stimulus
      plan_row_t              plan[$];
      flow_item_t             f;
      flow_result_t           want;
      sfkh_pkg::endpoint_type ea;
      sfkh_pkg::endpoint_type eb;
      logic [31:0]            salt;
      int                     waited;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // IPv4: ties, extremes, ordering, and address bits that must be ignored
      plan.push_back(plan_row(MODE_V4, 0, 0, 0, 0, 0, 0, ORDER_B));
      plan.push_back(plan_row(MODE_V4, ONES64, ONES64, 16'hFFFF,
                              ONES64, ONES64, 16'hFFFF, ORDER_B));
      plan.push_back(plan_row(MODE_V4, 0, 1, 80, 0, 2, 443, ORDER_A));
      plan.push_back(plan_row(MODE_V4, 0, 2, 80, 0, 1, 443, ORDER_B));
      plan.push_back(plan_row(MODE_V4, 0, 7, 1000, 0, 7, 1001, ORDER_A));
      plan.push_back(plan_row(MODE_V4, 0, 7, 1001, 0, 7, 1000, ORDER_B));
      plan.push_back(plan_row(MODE_V4, ONES64, 64'hFFFF_FFFF_0000_0001, 16'h1234,
                              64'h0123_4567_89AB_CDEF, 64'h2, 16'h1234, ORDER_A));
      plan.push_back(plan_row(MODE_V4, 0, 64'h5, 9, ONES64, 64'h4, 9, ORDER_B));
      plan.push_back(plan_row(MODE_V4, 0, 64'hFFFF_FFFF, 16'hFFFF, 0, 0, 0, ORDER_B));
      plan.push_back(plan_row(MODE_V4, 0, 64'h8000_0000, 1, 0, 64'h7FFF_FFFF, 1, ORDER_B));
      plan.push_back(plan_row(MODE_V4, 64'hDEAD_BEEF_0BAD_F00D, 64'h0A00_0001, 16'd53,
                              0, 64'hC0A8_0001, 16'd5353, ORDER_CALC));
      // IPv6: ties, upper half decides, lower half decides, port decides
      plan.push_back(plan_row(MODE_V6, 0, 0, 0, 0, 0, 0, ORDER_B));
      plan.push_back(plan_row(MODE_V6, ONES64, ONES64, 16'hFFFF,
                              ONES64, ONES64, 16'hFFFF, ORDER_B));
      plan.push_back(plan_row(MODE_V6, 0, ONES64, 0, 1, 0, 0, ORDER_A));
      plan.push_back(plan_row(MODE_V6, 5, ONES64, 1, 5, 0, 1, ORDER_B));
      plan.push_back(plan_row(MODE_V6, 5, 9, 16'hFFFF, 5, 9, 0, ORDER_B));
      plan.push_back(plan_row(MODE_V6, 5, 9, 2, 5, 9, 3, ORDER_A));
      plan.push_back(plan_row(MODE_V6, 64'h8000_0000_0000_0000, 0, 0,
                              64'h7FFF_FFFF_FFFF_FFFF, ONES64, 16'hFFFF, ORDER_B));
      plan.push_back(plan_row(MODE_V6, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                              16'hAAAA, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                              16'h5555, ORDER_B));
      plan.push_back(plan_row(MODE_V6, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
                              16'h0050, 64'h0123_4567_89AB_CDEF, 64'h0011_2233_4455_6677,
                              16'h01BB, ORDER_CALC));

      tx_idle_pct = 11;
      rx_idle_pct = 76;
      foreach (plan[i]) begin
         f  = plan[i].item;
         ea = endpoint_of(f.mode, f.addr_a_hi, f.addr_a_lo, f.port_a);
         eb = endpoint_of(f.mode, f.addr_b_hi, f.addr_b_lo, f.port_b);
         case (plan[i].pick)
            ORDER_A: want = hashed_flow(f.mode, ea, eb, salt_shadow);
            ORDER_B: want = hashed_flow(f.mode, eb, ea, salt_shadow);
            default: want = predict_flow(f, salt_shadow);
         endcase
         send_flow(f, want);
      end

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               tx_idle_pct = 11;
               rx_idle_pct = 76;
            end
            1: begin
               tx_idle_pct = 76;
               rx_idle_pct = 11;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
         endcase
         for (int chunk = 0; chunk < 4; chunk++) begin
            case (chunk)
               0: salt = 32'hFFFF_FFFF;
               2: salt = 32'h0000_0000;
               default: salt = $urandom;
            endcase
            write_salt(salt);
            // stall the result side while items keep coming
            if (phase == 2 && chunk == 1) hold_requests++;
            repeat (100) begin
               f           = '0;
               f.mode      = ip_mode_t'($urandom_range(1));
               f.addr_a_hi = {$urandom, $urandom};
               f.addr_a_lo = {$urandom, $urandom};
               f.port_a    = 16'($urandom);
               f.addr_b_hi = {$urandom, $urandom};
               f.addr_b_lo = {$urandom, $urandom};
               f.port_b    = 16'($urandom);
               // force ties at each level of the ordering
               case ($urandom_range(5))
                  0: begin
                     f.addr_b_hi = f.addr_a_hi;
                     f.addr_b_lo = f.addr_a_lo;
                     f.port_b    = f.port_a;
                  end
                  1: begin
                     f.addr_b_hi = f.addr_a_hi;
                     f.addr_b_lo = f.addr_a_lo;
                  end
                  2: f.addr_b_hi = f.addr_a_hi;
                  3: f.addr_b_lo[31:0] = f.addr_a_lo[31:0];
                  default: ;
               endcase
               send_flow(f, predict_flow(f, salt_shadow));
            end
         end
      end

      req_tvalid <= 1'b0;
      waited = 0;
      while (expected_flows.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (40) @(posedge clock);
      if (expected_flows.size() != 0)
         note_mismatch("results never delivered", 64'(expected_flows.size()), 64'd0);
      if (mismatches == 0) begin
         $display("[symmetric_flow_key_hash] OK");
      end else begin
         $display("[symmetric_flow_key_hash] ERROR");
      end
      $finish;
   end

endmodule
